// ===== design/shortest_job_first_queue_assert.svh =====
// assertion macros shared by the shortest-job-first queue modules
`ifndef SHORTEST_JOB_FIRST_QUEUE_ASSERT_SVH
`define SHORTEST_JOB_FIRST_QUEUE_ASSERT_SVH

// condition holds at every edge out of reset
`define SJFQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sjfq invariant violated");

// consequent holds in the same cycle as the antecedent
`define SJFQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sjfq same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define SJFQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sjfq next-cycle check failed");

`endif

// ===== design/sjfq_pkg.sv =====
// types and constants of the shortest-job-first queue
package sjfq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] job_size;
    logic [TAG_W-1:0]  job_tag;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] out_size;
    logic [TAG_W-1:0]  out_tag;
    logic [OCC_W-1:0]  occupancy;
  } out_word_t;

  // one queued job
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_cmd_t;

endpackage

// ===== design/sjfq_cell.sv =====
// one compare-and-shift cell of the sorted queue
module sjfq_cell (
  input  logic               clk,
  input  sjfq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               prev_open,
  input  sjfq_pkg::entry_t   prev_entry,
  input  sjfq_pkg::entry_t   next_entry,
  output logic               open,
  output sjfq_pkg::entry_t   entry
);

  sjfq_pkg::entry_t entry_r;
  sjfq_pkg::entry_t entry_nxt;

  // open: the new job lands here or in a lower cell; equal keys stay ahead
  assign open  = !occupied || (entry_r.size > cmd.item.size);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.enq && open) begin
      entry_nxt = prev_open ? prev_entry : cmd.item;
    end else if (cmd.deq) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== design/shortest_job_first_queue.sv =====
// top level of the shortest-job-first queue: cell row, fill count, result register
// Bounded shortest-job-first queue. Each input word either enqueues a job
// (op 0, key job_size, tag job_tag) or pops the job with the smallest size
// (op 1). Jobs of equal size leave in arrival order. Every input word gives
// exactly one result word: status 0 enqueued, 1 dropped because full,
// 2 dequeued (out_size/out_tag carry the job), 3 empty; out_size and out_tag
// are 0 unless a job was dequeued, and occupancy is the job count after the
// request (its low 5 bits). The queue is a row of QUEUE_DEPTH cells, each
// holding one job in sorted order; on an enqueue every cell compares the key
// with its own in parallel and the cells above the insertion point move up
// one place, on a dequeue every cell takes its upper neighbor's job. The block
// takes a new word every cycle while the output register is empty or being read;
// the result appears in the output register the cycle after acceptance and
// in_ready stays high while that register is empty or being read. The
// critical path is one 32-bit compare per cell plus the shift select.
module shortest_job_first_queue #(
  parameter int unsigned QUEUE_DEPTH = sjfq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sjfq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sjfq_pkg::out_word_t out_word
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // fill count and output register
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  sjfq_pkg::out_word_t out_word_r, out_word_nxt;

  logic in_fire;
  logic full, empty;
  logic is_enq, is_deq;

  sjfq_pkg::cell_cmd_t cmd;
  sjfq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_open;

  // accept while the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign is_enq = (in_word.op == sjfq_pkg::OP_ENQ);
  assign is_deq = (in_word.op == sjfq_pkg::OP_DEQ);

  // dropped or empty requests leave the cells alone
  assign cmd.enq           = in_fire && is_enq && !full;
  assign cmd.deq           = in_fire && is_deq && !empty;
  assign cmd.item.size     = in_word.job_size;
  assign cmd.item.tag      = in_word.job_tag;

  // row of cells, lowest key in cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             prev_open;
    sjfq_pkg::entry_t prev_entry;
    sjfq_pkg::entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_open  = 1'b0;
      assign prev_entry = cmd.item;
    end else begin : g_mid
      assign prev_open  = cell_open[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      // top cell becomes free on a pop, its contents no longer matter
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    sjfq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (cnt_r > CNT_W'(i)),
      .prev_open  (prev_open),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .open       (cell_open[i]),
      .entry      (cell_entry[i])
    );
  end

  // result word and count update
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt         = 1'b1;
      out_word_nxt.out_size = '0;
      out_word_nxt.out_tag  = '0;
      if (is_enq) begin
        if (full) begin
          out_word_nxt.status = sjfq_pkg::ST_DROPPED;
        end else begin
          out_word_nxt.status = sjfq_pkg::ST_ENQUEUED;
          cnt_nxt             = cnt_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_word_nxt.status = sjfq_pkg::ST_EMPTY;
        end else begin
          out_word_nxt.status   = sjfq_pkg::ST_DEQUEUED;
          out_word_nxt.out_size = cell_entry[0].size;
          out_word_nxt.out_tag  = cell_entry[0].tag;
          cnt_nxt               = cnt_r - CNT_W'(1);
        end
      end
      // only the low bits of the count fit the field
      out_word_nxt.occupancy = sjfq_pkg::OCC_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `include "shortest_job_first_queue_assert.svh"

  // count never runs past the row
  `SJFQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(QUEUE_DEPTH))
  // an accepted enqueue into a non-full queue grows the count by one
  `SJFQ_ASSERT_NEXT(a_enq_grows, in_fire && is_enq && !full,
                    cnt_r == $past(cnt_r) + CNT_W'(1))
  // an accepted word always leaves a result behind
  `SJFQ_ASSERT_NEXT(a_fire_result, in_fire, out_valid_r)
  // an empty report means nothing was queued
  `SJFQ_ASSERT_SAME(a_empty_zero,
                    out_valid_r && out_word_r.status == sjfq_pkg::ST_EMPTY,
                    out_word_r.occupancy == '0 && cnt_r == '0)

endmodule

// ===== bench/tb_shortest_job_first_queue.sv =====
// testbench for the shortest-job-first queue: directed and random words checked against a sorted job list
module tb_shortest_job_first_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import sjfq_pkg::*;

  localparam int unsigned DEPTH        = DEFAULT_QUEUE_DEPTH;
  localparam int unsigned RANDOM_WORDS = 1030;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 60;   // long receiver hold-off
  localparam int unsigned HOLD_EVERY   = 350;  // accepted words between long hold-offs
  localparam int unsigned QUIET_TAIL   = 150;  // last words run with no idling
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned END_CYCLES   = 20;

  // one pending request; wait_empty makes the sender pause until every result is in
  typedef struct {
    in_word_t word;
    bit       wait_empty;
  } job_request_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  job_request_t job_requests[$];     // words still to be offered
  entry_t       queued_jobs[$];      // predicted queue contents, ascending size
  out_word_t    awaited_results[$];  // predicted result words, oldest first

  int unsigned total_words  = 0;
  int unsigned sent_cnt     = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned fail_cnt     = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned long_holds   = 0;

  shortest_job_first_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // applies one request to the predicted queue and returns the result word it gives
  function automatic out_word_t sjf_result(in_word_t w);
    out_word_t   r;
    entry_t      job;
    int unsigned pos;
    r = '0;
    if (w.op == OP_ENQ) begin
      if (queued_jobs.size() >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        // goes behind every job of equal size, so ties leave in arrival order
        pos = 0;
        while (pos < queued_jobs.size() && queued_jobs[pos].size <= w.job_size) pos++;
        job.size = w.job_size;
        job.tag  = w.job_tag;
        queued_jobs.insert(pos, job);
        r.status = ST_ENQUEUED;
      end
    end else if (queued_jobs.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status   = ST_DEQUEUED;
      r.out_size = queued_jobs[0].size;
      r.out_tag  = queued_jobs[0].tag;
      queued_jobs.delete(0);
    end
    r.occupancy = OCC_W'(queued_jobs.size());
    return r;
  endfunction

  // sizes lean toward a few small values so that ties are common
  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SIZE_W'($urandom_range(0, 7));
      4, 5, 6, 7: return $urandom();
      8:          return $urandom_range(0, 1) ? {SIZE_W{1'b1}} : {SIZE_W{1'b0}};
      default:    return {SIZE_W{1'b1}} - SIZE_W'($urandom_range(0, 7));
    endcase
  endfunction

  // idling comes and goes in stretches of 128 words and stops for the tail
  function automatic bit idling_on();
    return (accepted_cnt + QUIET_TAIL < total_words) && ((accepted_cnt / 128) % 3 != 0);
  endfunction

  task automatic add_job(logic op, logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag,
                         bit wait_empty);
    job_request_t r;
    r.word.op       = op;
    r.word.job_size = size;
    r.word.job_tag  = tag;
    r.wait_empty    = wait_empty;
    job_requests.push_back(r);
  endtask

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("mismatch %0d at cycle %0d: %s", fail_cnt, cycle_cnt, msg);
    end
  endtask

  // sender: offers the next word at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (!rst_n || (in_valid && accepted_cnt != sent_cnt)) begin
      // in reset, or the offered word is still waiting for in_ready
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (job_requests.size() == 0 ||
                 (job_requests[0].wait_empty && awaited_results.size() != 0)) begin
      // nothing left, or pausing until the queue's results have all come back
      in_valid <= 1'b0;
    end else if (idling_on() && $urandom_range(0, 7) == 0) begin
      // random burst of idle cycles
      gap_left <= $urandom_range(0, 2);
      in_valid <= 1'b0;
    end else begin
      in_word  <= job_requests[0].word;
      in_valid <= 1'b1;
      job_requests.delete(0);
      sent_cnt <= sent_cnt + 1;
    end
  end

  // receiver: random stall bursts plus two long hold-offs that back up the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_holds < 2 && accepted_cnt >= HOLD_EVERY * (long_holds + 1)) begin
      hold_left  <= HOLD_CYCLES - 1;
      long_holds <= long_holds + 1;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idling_on() && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predicts on each accepted input word, checks each accepted result word
  always @(posedge clk) begin
    out_word_t want;
    cycle_cnt++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(sjf_result(in_word));
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result word: status %0d size %h tag %h occ %0d",
                                 out_word.status, out_word.out_size, out_word.out_tag,
                                 out_word.occupancy));
        end else begin
          want = awaited_results.pop_front();
          if (out_word.status !== want.status || out_word.out_size !== want.out_size ||
              out_word.out_tag !== want.out_tag || out_word.occupancy !== want.occupancy) begin
            note_failure($sformatf(
              "result %0d: expected status %0d size %h tag %h occ %0d, got %0d %h %h %0d",
              checked_cnt, want.status, want.out_size, want.out_tag, want.occupancy,
              out_word.status, out_word.out_size, out_word.out_tag, out_word.occupancy));
          end
        end
        checked_cnt++;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(negedge clk);
    $display("shortest_job_first_queue regression: fail");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned phase_len;
    int unsigned enq_pct;
    int unsigned n_random;

    // pop from an empty queue
    add_job(OP_DEQ, '0, '0, 1'b0);
    // extremes of size and tag
    add_job(OP_ENQ, {SIZE_W{1'b0}}, {TAG_W{1'b0}}, 1'b0);
    add_job(OP_ENQ, {SIZE_W{1'b1}}, {TAG_W{1'b1}}, 1'b0);
    // equal sizes must come out in arrival order, also at the top of the range
    add_job(OP_ENQ, SIZE_W'(5), TAG_W'(8'h10), 1'b0);
    add_job(OP_ENQ, SIZE_W'(5), TAG_W'(8'h11), 1'b0);
    add_job(OP_ENQ, SIZE_W'(5), TAG_W'(8'h12), 1'b0);
    add_job(OP_ENQ, {SIZE_W{1'b1}}, TAG_W'(8'h01), 1'b0);
    // descending sizes land in the middle of the list until it is full
    for (int k = 0; k < DEPTH - 6; k++) begin
      add_job(OP_ENQ, SIZE_W'(9 - k), TAG_W'(8'h20 + k), 1'b0);
    end
    // enqueue on a full queue is dropped
    add_job(OP_ENQ, SIZE_W'(1), TAG_W'(8'h55), 1'b0);
    for (int k = 0; k < 3; k++) begin
      add_job(OP_DEQ, $urandom(), TAG_W'($urandom_range(0, 255)), 1'b0);
    end

    // random phases that lean toward filling, balancing or draining the queue;
    // some phases start only once every outstanding result is back
    n_random = 0;
    while (n_random < RANDOM_WORDS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0:       enq_pct = 90;
        1:       enq_pct = 65;
        2:       enq_pct = 50;
        default: enq_pct = 30;
      endcase
      for (int k = 0; k < phase_len; k++) begin
        add_job(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ, random_size(),
                TAG_W'($urandom_range(0, 255)),
                k == 0 && (n_random == 0 || $urandom_range(0, 3) == 0));
        n_random++;
      end
    end
    total_words = job_requests.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_words || awaited_results.size() != 0) @(negedge clk);
    // run on to catch stray result words
    repeat (END_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("shortest_job_first_queue regression: pass");
    end else begin
      $display("shortest_job_first_queue regression: fail");
    end
    $finish;
  end

endmodule
